// ----- design/arx_block_cipher_64_defines.svh -----
// Assertion helpers shared by the cipher RTL.
// Each check is clocked on the rising edge and is off while reset is asserted.
`ifndef ARX_BLOCK_CIPHER_64_DEFINES_SVH
`define ARX_BLOCK_CIPHER_64_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARXC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARXC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- design/arxc_pkg.sv -----
`timescale 1ns / 1ps

package arxc_pkg;

	// Number of rounds; each round is one pipeline stage.
	localparam int NUM_ROUNDS = 32;

	localparam int WORD_W    = 32;
	localparam int NUM_KEYS  = 4;
	localparam int KEY_SEL_W = $clog2(NUM_KEYS);
	localparam int CFG_IDX_W = 8;

	localparam int ROT_X = 8;
	localparam int ROT_Y = 3;

	// Operation codes carried by the mode field.
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_KEYS-1:0] key_arr_t;

	// One request as it enters the block.
	typedef struct packed {
		logic  mode;
		word_t block_x;
		word_t block_y;
	} in_t;

	// One result as it leaves the block.
	typedef struct packed {
		word_t out_x;
		word_t out_y;
	} out_t;

	// Contents of one pipeline stage.
	typedef struct packed {
		logic  valid;
		logic  mode;
		word_t x;
		word_t y;
	} stage_t;

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (WORD_W - n));
	endfunction

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// Forward round: returns {x, y}.
	function automatic logic [2*WORD_W-1:0] enc_round(input word_t x, input word_t y,
			input word_t k);
		word_t nx;
		word_t ny;
		nx = (rotr(x, ROT_X) + y) ^ k;
		ny = rotl(y, ROT_Y) ^ nx;
		return {nx, ny};
	endfunction

	// Inverse round: returns {x, y}.
	function automatic logic [2*WORD_W-1:0] dec_round(input word_t x, input word_t y,
			input word_t k);
		word_t nx;
		word_t ny;
		ny = rotr(y ^ x, ROT_Y);
		nx = rotl((x ^ k) - ny, ROT_X);
		return {nx, ny};
	endfunction

endpackage

// ----- design/arxc_key_file.sv -----
`timescale 1ns / 1ps

module arxc_key_file (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [arxc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  arxc_pkg::word_t             cfg_data,
	output arxc_pkg::key_arr_t          keys
);
	import arxc_pkg::*;

	key_arr_t key_q;
	logic     wr_en;

	// A write to an index past the last key word is dropped.
	assign wr_en = cfg_valid && cfg_ready
		&& (cfg_index < CFG_IDX_W'(NUM_KEYS));

	// Key word registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[cfg_index[KEY_SEL_W-1:0]] <= cfg_data;
		end
	end

	assign keys = key_q;

endmodule

// ----- design/arxc_round.sv -----
`timescale 1ns / 1ps

module arxc_round (
	input  logic             clk,
	input  logic             arst_n,
	input  arxc_pkg::stage_t stage_in,
	input  arxc_pkg::word_t  enc_key,
	input  arxc_pkg::word_t  dec_key,
	output arxc_pkg::stage_t stage_out
);
	import arxc_pkg::*;

	logic [2*WORD_W-1:0] enc_res;
	logic [2*WORD_W-1:0] dec_res;
	logic                valid_s1;
	logic                mode_s1;
	word_t               x_s1;
	word_t               y_s1;

	// Both directions are computed; the mode bit picks one.
	always_comb begin
		enc_res = enc_round(stage_in.x, stage_in.y, enc_key);
		dec_res = dec_round(stage_in.x, stage_in.y, dec_key);
	end

	// Valid bit is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	// Payload registers load every cycle.
	always_ff @(posedge clk) begin
		mode_s1 <= stage_in.mode;
		if (stage_in.mode == MODE_DECRYPT) begin
			{x_s1, y_s1} <= dec_res;
		end else begin
			{x_s1, y_s1} <= enc_res;
		end
	end

	assign stage_out = '{valid: valid_s1, mode: mode_s1, x: x_s1, y: y_s1};

endmodule

// ----- design/arx_block_cipher_64.sv -----
// A request travels from the start edge through the round pipeline to the cycle that carries rsp_valid.
// Throughput: one request per cycle; busy is low in every cycle but the first after reset.
// The round pipeline has one register stage per round, so depth sets the latency.
// Reset clears all valid bits and the key words to zero; busy is high during reset.
// The result is shown for one cycle with rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`include "arx_block_cipher_64_defines.svh"

module arx_block_cipher_64 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  arxc_pkg::in_t                  req,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [arxc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  arxc_pkg::word_t                cfg_data,
	output logic                           rsp_valid,
	output arxc_pkg::out_t                 rsp
);
	import arxc_pkg::*;

	logic     busy_q;
	logic     accept;
	key_arr_t keys;
	stage_t   stage_w [0:NUM_ROUNDS];

	// Hold off requests during reset and in the cycle after reset is released.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy_q;

	// Key word storage.
	arxc_key_file u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys)
	);

	// Pipeline entry.
	assign stage_w[0] = '{valid: accept, mode: req.mode, x: req.block_x, y: req.block_y};

	// One stage per round; decryption walks the key words in reverse order.
	for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
		localparam int ENC_K = i % NUM_KEYS;
		localparam int DEC_K = (NUM_ROUNDS - 1 - i) % NUM_KEYS;

		arxc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (stage_w[i]),
			.enc_key   (keys[ENC_K]),
			.dec_key   (keys[DEC_K]),
			.stage_out (stage_w[i+1])
		);
	end

	// Result drive.
	assign rsp_valid = stage_w[NUM_ROUNDS].valid;
	assign rsp       = '{out_x: stage_w[NUM_ROUNDS].x, out_y: stage_w[NUM_ROUNDS].y};

	// Every accepted request comes out at the end of the round pipeline, and nothing else does.
	`ARXC_ASSERT_SAME(a_latency, clk, arst_n, 1'b1, rsp_valid == $past(accept, NUM_ROUNDS))

	// An in-range key write lands in the addressed key word.
	`ARXC_ASSERT_NEXT(a_key_write, clk, arst_n,
		cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_KEYS)),
		keys[$past(cfg_index[KEY_SEL_W-1:0])] == $past(cfg_data))

	// An out-of-range key write changes nothing.
	`ARXC_ASSERT_NEXT(a_key_ignore, clk, arst_n,
		cfg_valid && cfg_ready && (cfg_index >= CFG_IDX_W'(NUM_KEYS)), $stable(keys))

endmodule

// ----- dv/tb_arx_block_cipher_64.sv -----
`timescale 1ns / 1ps

module tb_arx_block_cipher_64;
	import arxc_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int RESET_CYC  = 8;
	localparam int RUN_LIMIT  = 400000;
	localparam int PHASE_ITEMS = 170;
	localparam int NUM_PHASES = 6;

	// Key register indexes and the top of the index space.
	localparam logic [CFG_IDX_W-1:0] KEY_IDX_0   = 0;
	localparam logic [CFG_IDX_W-1:0] KEY_IDX_1   = 1;
	localparam logic [CFG_IDX_W-1:0] KEY_IDX_2   = 2;
	localparam logic [CFG_IDX_W-1:0] KEY_IDX_3   = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	typedef enum logic {
		ROW_BLOCK,
		ROW_KEY
	} row_kind_t;

	// One row of the directed table: a block request or a key write.
	typedef struct packed {
		row_kind_t              kind;
		logic                   mode;
		word_t                  x;
		word_t                  y;
		logic [CFG_IDX_W-1:0]   idx;
		word_t                  data;
		logic                   typed;
		word_t                  ex;
		word_t                  ey;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_t                  req;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	word_t                cfg_data;
	logic                 rsp_valid;
	out_t                 rsp;

	word_t     key_model [NUM_KEYS];
	out_t      expected_blocks [$];
	out_t      staged_result;
	out_t      last_cipher;
	stim_row_t directed_rows [$];
	int        errors;
	int        cycle_count;

	arx_block_cipher_64 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Computes the transformed block from the current key words.
	function automatic out_t predict_block(input in_t item);
		word_t x;
		word_t y;
		out_t  res;
		int    rd;
		x = item.block_x;
		y = item.block_y;
		if (item.mode == MODE_ENCRYPT) begin
			for (rd = 0; rd < NUM_ROUNDS; rd++) begin
				x = {x[7:0], x[31:8]} + y;
				x = x ^ key_model[rd % NUM_KEYS];
				y = {y[28:0], y[31:29]} ^ x;
			end
		end else begin
			for (rd = NUM_ROUNDS - 1; rd >= 0; rd--) begin
				y = y ^ x;
				y = {y[2:0], y[31:3]};
				x = (x ^ key_model[rd % NUM_KEYS]) - y;
				x = {x[23:0], x[31:24]};
			end
		end
		res.out_x = x;
		res.out_y = y;
		return res;
	endfunction

	// Mostly random words, with zero, all ones and single-bit patterns mixed in.
	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			2: w = word_t'(1) << $urandom_range(WORD_W - 1);
			3: w = ~(word_t'(1) << $urandom_range(WORD_W - 1));
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Scoreboard: records accepted requests and checks each result in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid) begin
				if (expected_blocks.size() == 0) begin
					$error("result with no request outstanding: out_x %h out_y %h",
						rsp.out_x, rsp.out_y);
					errors++;
				end else begin
					if (rsp.out_x !== expected_blocks[0].out_x) begin
						$error("out_x mismatch: expected %h, got %h",
							expected_blocks[0].out_x, rsp.out_x);
						errors++;
					end
					if (rsp.out_y !== expected_blocks[0].out_y) begin
						$error("out_y mismatch: expected %h, got %h",
							expected_blocks[0].out_y, rsp.out_y);
						errors++;
					end
					void'(expected_blocks.pop_front());
				end
			end
			if (start && !busy) begin
				expected_blocks.push_back(staged_result);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Presents one request after a random number of idle cycles.
	task automatic send_block(input in_t item, input int idle_pct, input logic typed,
			input out_t typed_exp);
		int gaps;
		gaps = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct && gaps < 16) gaps++;
		repeat (gaps) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		staged_result = typed ? typed_exp : predict_block(item);
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
	endtask

	// Stops requesting and waits until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_blocks.size() != 0) @(negedge clk);
	endtask

	// Writes one key register once the pipeline is empty.
	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input word_t data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= KEY_IDX_3) key_model[idx[KEY_SEL_W-1:0]] = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_keys(input word_t k0, input word_t k1, input word_t k2,
			input word_t k3);
		write_key(KEY_IDX_0, k0);
		write_key(KEY_IDX_1, k1);
		write_key(KEY_IDX_2, k2);
		write_key(KEY_IDX_3, k3);
		// Writes above the last key index must leave the keys alone.
		write_key(CFG_IDX_W'($urandom_range(int'(KEY_IDX_3) + 1, int'(CFG_IDX_TOP))),
			$urandom);
	endtask

	// Builds a random request: round trips of the last ciphertext, edge words, noise.
	function automatic in_t pick_request();
		in_t item;
		int  sel;
		sel = $urandom_range(99);
		if (sel < 20) begin
			item.mode    = MODE_DECRYPT;
			item.block_x = last_cipher.out_x;
			item.block_y = last_cipher.out_y;
		end else if (sel < 45) begin
			item.mode    = 1'($urandom_range(1));
			item.block_x = pick_word();
			item.block_y = pick_word();
		end else begin
			item.mode    = 1'($urandom_range(1));
			item.block_x = $urandom;
			item.block_y = $urandom;
		end
		return item;
	endfunction

	initial begin
		in_t  item;
		out_t typed_exp;
		int   phase;
		int   n;
		int   idle_pct;
		int   idle_plan [NUM_PHASES];

		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		errors      = 0;
		cycle_count = 0;
		staged_result = '0;
		last_cipher = '0;
		idle_plan   = '{0, 70, 6, 70, 0, 6};
		for (n = 0; n < NUM_KEYS; n++) key_model[n] = '0;

		// Directed table: zero keys after reset, then extreme and mixed keys.
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'h0, 32'h0, 8'h0, 32'h0,
			1'b1, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_DECRYPT, 32'h0, 32'h0, 8'h0, 32'h0,
			1'b1, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_DECRYPT, 32'hFFFFFFFF, 32'h0, 8'h0,
			32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'h0, 32'hFFFFFFFF, 8'h0,
			32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'h80000000, 32'h00000001,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, KEY_IDX_0,
			32'hFFFFFFFF, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, KEY_IDX_1,
			32'h01234567, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, KEY_IDX_2,
			32'h89ABCDEF, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, KEY_IDX_3,
			32'hFFFFFFFF, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, KEY_IDX_3 + 8'd1,
			32'hDEADBEEF, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_KEY, MODE_ENCRYPT, 32'h0, 32'h0, CFG_IDX_TOP,
			32'h5A5A5A5A, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'h0, 32'h0, 8'h0, 32'h0,
			1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_DECRYPT, 32'h0, 32'h0, 8'h0, 32'h0,
			1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_ENCRYPT, 32'h12345678, 32'h9ABCDEF0,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});
		directed_rows.push_back('{ROW_BLOCK, MODE_DECRYPT, 32'h12345678, 32'h9ABCDEF0,
			8'h0, 32'h0, 1'b0, 32'h0, 32'h0});

		// Reset is held for a fixed number of cycles, once.
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_KEY) begin
				write_key(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				item.mode        = directed_rows[i].mode;
				item.block_x     = directed_rows[i].x;
				item.block_y     = directed_rows[i].y;
				typed_exp.out_x  = directed_rows[i].ex;
				typed_exp.out_y  = directed_rows[i].ey;
				send_block(item, 0, directed_rows[i].typed, typed_exp);
			end
		end

		// Random phases, each with its own key setting and idle rate.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: set_keys('1, '1, '1, '1);
				1: set_keys('0, '0, '0, '0);
				2: set_keys(32'hAAAAAAAA, 32'h55555555, 32'h0, 32'hFFFFFFFF);
				default: set_keys($urandom, $urandom, $urandom, $urandom);
			endcase
			idle_pct = idle_plan[phase];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Let the pipeline run dry once in the middle of a phase.
				if (phase == 3 && n == PHASE_ITEMS / 2) drain();
				item = pick_request();
				if (item.mode == MODE_ENCRYPT) begin
					last_cipher = predict_block(item);
				end
				send_block(item, idle_pct, 1'b0, '0);
			end
		end

		// Wait for the last results, then let the clock run idle before the verdict.
		drain();
		repeat (NUM_ROUNDS + 8) @(negedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
